[hdl/spff_pkg.sv]
package spff_pkg;

  // Width of values, factors and table entries
  localparam int VAL_W = 16;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  // Divider: quotient bits retired per cycle and cycles per divide
  localparam int DIV_BITS_PER_CYC = 2;
  localparam int DIV_CYCLES       = VAL_W / DIV_BITS_PER_CYC;

  // One queued item: the value and whether it needs no factoring
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             trivial;
  } item_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } qhead_t;

endpackage

[hdl/spff_table.sv]
module spff_table import spff_pkg::*; #(
  parameter int TABLE_SIZE = 65536
) (
  input  logic             clk,
  input  logic             rst_n,
  output logic             ready,
  input  logic             rd_en,
  input  logic [VAL_W-1:0] rd_addr,
  output logic [VAL_W-1:0] rd_data
);

  // Only indices that fit in a value are ever read
  localparam int DEPTH = (TABLE_SIZE < 65536) ? TABLE_SIZE : 65536;
  localparam int AW    = $clog2(DEPTH);

  // Largest marker i with i*i below the depth
  function automatic int isqrt_below(input int n);
    int r;
    r = 1;
    for (int k = 1; k < 256; k++) begin
      if (k * k < n) r = k;
    end
    return r;
  endfunction

  localparam int IMAX = isqrt_below(DEPTH);
  localparam int IW   = $clog2(IMAX + 1);

  localparam logic [1:0] S_INIT  = 2'd0;
  localparam logic [1:0] S_START = 2'd1;
  localparam logic [1:0] S_MARK  = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [AW-1:0]    a_r, a_nxt;
  logic [IW-1:0]    i_r, i_nxt;
  logic [AW:0]      j_r, j_nxt;
  logic [AW:0]      j_step;
  logic             we;
  logic [AW-1:0]    wr_addr;
  logic [VAL_W-1:0] wr_data;
  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rd_data_r;

  assign j_step = j_r + (AW+1)'(i_r);

  // Sieve sequencer: identity sweep, then mark multiples with i running down,
  // so the smallest marker is the last one written
  always_comb begin
    state_nxt = state_r;
    a_nxt     = a_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    we        = 1'b0;
    wr_addr   = a_r;
    wr_data   = VAL_W'(a_r);
    unique case (state_r)
      S_INIT: begin
        we    = 1'b1;
        a_nxt = a_r + 1'b1;
        if (a_r == AW'(DEPTH - 1)) begin
          i_nxt     = IW'(IMAX);
          state_nxt = S_START;
        end
      end
      S_START: begin
        j_nxt     = (AW+1)'(i_r) * (AW+1)'(i_r);
        state_nxt = S_MARK;
      end
      S_MARK: begin
        we      = 1'b1;
        wr_addr = j_r[AW-1:0];
        wr_data = VAL_W'(i_r);
        j_nxt   = j_step;
        if (j_step >= (AW+1)'(DEPTH)) begin
          if (i_r == IW'(2)) begin
            state_nxt = S_DONE;
          end else begin
            i_nxt     = i_r - 1'b1;
            state_nxt = S_START;
          end
        end
      end
      S_DONE: begin
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      a_r     <= '0;
    end else begin
      state_r <= state_nxt;
      a_r     <= a_nxt;
    end
    i_r <= i_nxt;
    j_r <= j_nxt;
  end

  // Table storage: one write port for the sieve, one registered read port
  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[rd_addr[AW-1:0]];
  end

  assign rd_data = rd_data_r;
  assign ready   = (state_r == S_DONE);

endmodule

[hdl/spff_front.sv]
module spff_front import spff_pkg::*; #(
  parameter int TABLE_SIZE = 65536
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             table_ready,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [VAL_W-1:0] in_value,
  output qhead_t           head,
  input  logic             pop
);

  item_t          q_mem [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic           push;
  item_t          in_item;

  // Classify: zero, one and out-of-table values give a single empty result
  always_comb begin
    in_item.value   = in_value;
    in_item.trivial = (in_value < VAL_W'(2)) ||
                      ({16'd0, in_value} >= 32'(TABLE_SIZE));
  end

  assign in_ready = table_ready && (cnt_r != (QAW+1)'(QDEPTH));
  assign push     = in_valid && in_ready;

  // Advance queue pointers on transfer in and pop out
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (QAW+1)'(push) - (QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_mem[wr_ptr_r] <= in_item;
  end

  assign head.valid = (cnt_r != '0);
  assign head.item  = q_mem[rd_ptr_r];

endmodule

[hdl/spff_div.sv]
module spff_div import spff_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [VAL_W-1:0] dividend,
  input  logic [VAL_W-1:0] divisor,
  output logic             done,
  output logic [VAL_W-1:0] quotient
);

  localparam int CW = $clog2(DIV_CYCLES);

  logic [VAL_W-1:0] rem_r, rem_nxt;
  logic [VAL_W-1:0] dq_r, dq_nxt;
  logic [VAL_W-1:0] dvs_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [VAL_W:0]   trial;

  // Restoring division, two quotient bits per cycle
  always_comb begin
    rem_nxt = rem_r;
    dq_nxt  = dq_r;
    trial   = '0;
    for (int k = 0; k < DIV_BITS_PER_CYC; k++) begin
      trial = {rem_nxt, dq_nxt[VAL_W-1]};
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = VAL_W'(trial - {1'b0, dvs_r});
        dq_nxt  = {dq_nxt[VAL_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[VAL_W-1:0];
        dq_nxt  = {dq_nxt[VAL_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == CW'(DIV_CYCLES - 1));
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == CW'(DIV_CYCLES - 1))) begin
        busy_r <= 1'b0;
      end
    end
    if (start) begin
      rem_r <= '0;
      dq_r  <= dividend;
      dvs_r <= divisor;
      cnt_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dq_r  <= dq_nxt;
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign done     = done_r;
  assign quotient = dq_r;

endmodule

[hdl/spff_back.sv]
module spff_back import spff_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  qhead_t           head,
  output logic             pop,
  output logic             rd_en,
  output logic [VAL_W-1:0] rd_addr,
  input  logic [VAL_W-1:0] rd_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [VAL_W-1:0] out_factor,
  output logic             out_last,
  output logic             out_no_factors
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_LOOK = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [VAL_W-1:0] rest_r, rest_nxt;
  logic [VAL_W-1:0] f_r, f_nxt;
  logic [VAL_W-1:0] q_r, q_nxt;
  logic             none_r, none_nxt;
  logic             div_start;
  logic             div_done;
  logic [VAL_W-1:0] div_quo;
  logic             out_free;
  logic             load;
  logic             out_valid_r;
  logic [VAL_W-1:0] out_factor_r;
  logic             out_last_r;
  logic             out_no_factors_r;

  spff_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rest_r),
    .divisor  (rd_data),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign out_free = !out_valid_r || out_ready;

  // Factor loop: look up smallest factor, divide it out, emit, repeat
  always_comb begin
    state_nxt = state_r;
    rest_nxt  = rest_r;
    f_nxt     = f_r;
    q_nxt     = q_r;
    none_nxt  = none_r;
    pop       = 1'b0;
    rd_en     = 1'b0;
    div_start = 1'b0;
    load      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          if (head.item.trivial) begin
            f_nxt     = '0;
            q_nxt     = VAL_W'(1);
            none_nxt  = 1'b1;
            state_nxt = S_EMIT;
          end else begin
            rest_nxt  = head.item.value;
            none_nxt  = 1'b0;
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        rd_en     = 1'b1;
        state_nxt = S_LOOK;
      end
      S_LOOK: begin
        f_nxt     = rd_data;
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          q_nxt     = div_quo;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          load = 1'b1;
          if (q_r == VAL_W'(1)) begin
            state_nxt = S_IDLE;
          end else begin
            rest_nxt  = q_r;
            state_nxt = S_READ;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign rd_addr = rest_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    rest_r <= rest_nxt;
    f_r    <= f_nxt;
    q_r    <= q_nxt;
    none_r <= none_nxt;
  end

  // Output register: hold until transfer, load when free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (load) begin
      out_factor_r     <= f_r;
      out_last_r       <= (q_r == VAL_W'(1));
      out_no_factors_r <= none_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_factor     = out_factor_r;
  assign out_last       = out_last_r;
  assign out_no_factors = out_no_factors_r;

endmodule

[hdl/smallest_prime_factor_factorizer_top.sv]
// Smallest-prime-factor factorizer.
//
// Input channel (in_valid/in_ready/in_value) takes one value per transfer.
// Result channel (out_valid/out_ready/out_factor/out_last/out_no_factors)
// gives that value's prime factors in nondecreasing order with multiplicity;
// out_last marks the final one. Zero, one, and values not below TABLE_SIZE
// give a single result with factor 0, out_last and out_no_factors set.
//
// After reset the block builds its smallest-factor table with a sieve and
// holds in_ready low until done: first an identity sweep over every entry,
// then a pass that marks the multiples of each marker, from the largest down.
//
// A four-entry queue separates intake from factoring, so values are taken
// while earlier ones are still worked on. Each factor takes a table read,
// a lookup that starts a 2-bit-per-cycle divider, the divide itself, and a
// load into the output register; an empty item goes straight to that
// register. A stalled receiver holds the output register, which stalls
// factoring; the queue keeps accepting until full.
module smallest_prime_factor_factorizer_top import spff_pkg::*; #(
  parameter int TABLE_SIZE = 65536
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [VAL_W-1:0] in_value,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [VAL_W-1:0] out_factor,
  output logic             out_last,
  output logic             out_no_factors
);

  logic             table_ready;
  logic             rd_en;
  logic [VAL_W-1:0] rd_addr;
  logic [VAL_W-1:0] rd_data;
  qhead_t           head;
  logic             pop;

  spff_table #(.TABLE_SIZE(TABLE_SIZE)) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .ready   (table_ready),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  spff_front #(.TABLE_SIZE(TABLE_SIZE)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .table_ready (table_ready),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_value    (in_value),
    .head        (head),
    .pop         (pop)
  );

  spff_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .pop            (pop),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_factor     (out_factor),
    .out_last       (out_last),
    .out_no_factors (out_no_factors)
  );

endmodule
